[hw/rtl/block_fir_convolution_unit_macros.svh]
// ----------------------------------------------------------------------------
// Block FIR convolution unit: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FIR_CONVOLUTION_UNIT_MACROS_SVH
`define BLOCK_FIR_CONVOLUTION_UNIT_MACROS_SVH

// Same-cycle implication.
`define FCU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fcu_pkg.sv]
// ----------------------------------------------------------------------------
// Block FIR convolution unit package
// Field widths, item and result types, sequencer states and MAC control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcu_pkg;

	localparam int TAPS_DEF = 32;
	localparam int SMP_W    = 12;
	localparam int COEF_W   = 16;
	localparam int IDX_W    = 6;
	localparam int FILT_W   = 35;

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          coef_index;
		logic signed [COEF_W-1:0]  coef_value;
		logic [SMP_W-1:0]          sample;
		logic                      block_end;
	} item_t;

	typedef struct packed {
		logic signed [FILT_W-1:0] filtered;
		logic                     last_of_block;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_WAIT,
		S_OUT
	} seq_state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

[hw/rtl/fcu_stream_if.sv]
// ----------------------------------------------------------------------------
// Block FIR convolution unit stream interface
// Valid/ready channel carrying one item of payload type payload_t.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcu_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[hw/rtl/block_fir_convolution_unit.sv]
// ----------------------------------------------------------------------------
// Block FIR convolution unit
// Linear convolution of sample blocks with a loaded Q1.15 coefficient table.
// ----------------------------------------------------------------------------
// Channels: item (sink) takes load items (mode 0) and sample items (mode 1);
// result (source) gives the 35-bit full-precision sum and a last marker.
// A load item writes one coefficient and gives no result;
// an index at or beyond TAPS is dropped.
// A sample item gives one result; with block_end set it gives TAPS results,
// the tail formed by shifting zeros, and the final one carries last_of_block.
// Each result takes one sweep of the shared multiply-accumulate over the
// taps, a drain through the memory read, product and accumulate registers,
// and the output state; the next item is taken once a plain sample's result
// is loaded, and a flushing sample holds the sequencer for one sweep per
// result, TAPS results in all.
// The coefficient and delay-line memories are read one tap a cycle.
// item.ready is high only while the sequencer idles; a waiting result does
// not block the next item, but a result is not overwritten until taken, so
// a stalled receiver holds the sequencer.
// Reset zeroes all coefficients and closes any block; the first sample of a
// block starts from a cleared delay line. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_fir_convolution_unit import fcu_pkg::*; #(
	parameter int  TAPS = TAPS_DEF,
	localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	fcu_stream_if.sink   item,
	fcu_stream_if.source result
);

	localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic             block_open_q;
	logic             end_q;
	logic [AW-1:0]    flush_left_q;
	logic [AW-1:0]    tap_q;
	logic [AW-1:0]    rptr_q;
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    wptr_nxt;
	result_t          res_q;
	logic             res_vld_q;

	logic             item_fire;
	logic             ld_fire;
	logic             smp_fire;
	logic             coef_we;
	logic             out_load;
	logic             zero_shift;
	logic             shift_we;
	logic             res_last;
	mac_ctl_t         mac_ctl;
	logic             mac_done;
	logic signed [FILT_W-1:0] mac_acc;
	logic [SMP_W-1:0]         dl_rdata;
	logic [COEF_W-1:0]        coef_rdata;

	assign item_fire  = item.valid && item.ready;
	assign ld_fire    = item_fire && (item.data.mode == MODE_LOAD);
	assign smp_fire   = item_fire && (item.data.mode == MODE_SAMPLE);
	assign coef_we    = ld_fire && (int'(item.data.coef_index) < TAPS);
	assign out_load   = (state_q == S_OUT) && (!res_vld_q || result.ready);
	assign zero_shift = out_load && (flush_left_q != '0);
	assign shift_we   = smp_fire || zero_shift;
	assign res_last   = end_q && (flush_left_q == '0);
	assign wptr_nxt   = (wptr_q == LAST_TAP) ? '0 : wptr_q + 1'b1;

	fcu_vmem #(
		.DEPTH (TAPS),
		.WIDTH (COEF_W)
	) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (1'b0),
		.we     (coef_we),
		.waddr  (item.data.coef_index[AW-1:0]),
		.wdata  (item.data.coef_value),
		.raddr  (tap_q),
		.rdata  (coef_rdata)
	);

	fcu_vmem #(
		.DEPTH (TAPS),
		.WIDTH (SMP_W)
	) u_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (smp_fire && !block_open_q),
		.we     (shift_we),
		.waddr  (wptr_nxt),
		.wdata  (smp_fire ? item.data.sample : '0),
		.raddr  (rptr_q),
		.rdata  (dl_rdata)
	);

	fcu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.smp    (dl_rdata),
		.coef   ($signed(coef_rdata)),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (smp_fire) state_d = S_MAC;
			end
			S_MAC: begin
				if (tap_q == LAST_TAP) state_d = S_WAIT;
			end
			S_WAIT: begin
				if (mac_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_d = zero_shift ? S_MAC : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item.ready    = (state_q == S_IDLE);
		result.valid  = res_vld_q;
		result.data   = res_q;
		mac_ctl.valid = (state_q == S_MAC);
		mac_ctl.first = (tap_q == '0);
		mac_ctl.last  = (tap_q == LAST_TAP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			block_open_q <= 1'b0;
			end_q        <= 1'b0;
			flush_left_q <= '0;
			tap_q        <= '0;
			rptr_q       <= '0;
			wptr_q       <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (smp_fire) begin
				block_open_q <= 1'b1;
				end_q        <= item.data.block_end;
				flush_left_q <= item.data.block_end ? LAST_TAP : '0;
			end else if (zero_shift) begin
				flush_left_q <= flush_left_q - 1'b1;
			end
			if (shift_we) begin
				wptr_q <= wptr_nxt;
				rptr_q <= wptr_nxt;
				tap_q  <= '0;
			end else if (state_q == S_MAC) begin
				rptr_q <= (rptr_q == '0) ? LAST_TAP : rptr_q - 1'b1;
				tap_q  <= (tap_q == LAST_TAP) ? '0 : tap_q + 1'b1;
			end
			if (out_load) begin
				res_vld_q <= 1'b1;
				if (res_last) block_open_q <= 1'b0;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.filtered      <= mac_acc;
			res_q.last_of_block <= res_last;
		end
	end

`include "block_fir_convolution_unit_macros.svh"

	`FCU_ASSERT_NOW(a_done_in_wait, mac_done, state_q == S_WAIT, "MAC sweep ended outside wait")
	`FCU_ASSERT_NEXT(a_hold_result, (state_q == S_OUT) && res_vld_q && !result.ready, state_q == S_OUT, "result overwritten while stalled")
	`FCU_ASSERT_NEXT(a_last_closes, out_load && res_last, !block_open_q, "block left open after last result")
	`FCU_ASSERT_NOW(a_flush_end, flush_left_q != '0, end_q, "tail flush without block end")

endmodule

[hw/rtl/fcu_vmem.sv]
// ----------------------------------------------------------------------------
// Block FIR convolution unit table memory
// One write port, one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcu_vmem #(
	parameter int  DEPTH = 32,
	parameter int  WIDTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			vld_q    <= (clr ? '0 : vld_q) | (we ? (DEPTH'(1) << waddr) : '0);
			rd_vld_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

[hw/rtl/fcu_mac.sv]
// ----------------------------------------------------------------------------
// Block FIR convolution unit multiply-accumulate
// Registered product of sample and coefficient, summed over one tap sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcu_mac import fcu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic [SMP_W-1:0]         smp,
	input  logic signed [COEF_W-1:0] coef,
	output logic                     done,
	output logic signed [FILT_W-1:0] acc
);

	localparam int PROD_W = SMP_W + COEF_W + 1;

	mac_ctl_t                 ctl_s1;
	mac_ctl_t                 ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [FILT_W-1:0] acc_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, smp}) * coef;
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + FILT_W'(prod_s2);
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule
